[hw/rtl/udfu_pkg.sv]
`timescale 1ns / 1ps
// DFU request engine package: state, opcode and action codes, result record.
// No dependencies.
package udfu_pkg;

  localparam int unsigned TRANSFER_SIZE_DEF = 1024;

  localparam logic [6:0] REQ_TYPE_CLASS = 7'h21;
  localparam logic [7:0] CMD_SET_ADDRESS = 8'h21;
  localparam logic [7:0] CMD_ERASE_SECTOR = 8'h41;

  localparam logic [31:0] APP_START_RST = 32'h0800_2000;
  localparam logic [31:0] FLASH_END_RST = 32'h0802_0000;
  localparam logic [23:0] POLL_WAIT_RST = 24'd100;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_APP_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLASH_END = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POLL_WAIT = 2'd2;

  localparam logic [2:0] REPLY_LEN_STATUS = 3'd6;
  localparam logic [2:0] REPLY_LEN_STATE = 3'd1;

  typedef enum logic [3:0] {
    ST_IDLE     = 4'd2,
    ST_DNSYNC   = 4'd3,
    ST_DNBUSY   = 4'd4,
    ST_DNIDLE   = 4'd5,
    ST_MANSYNC  = 4'd6,
    ST_MANIFEST = 4'd7,
    ST_UPIDLE   = 4'd9,
    ST_ERROR    = 4'd10
  } dfu_state_t;

  typedef enum logic [2:0] {
    OP_DNLOAD    = 3'd0,
    OP_UPLOAD    = 3'd1,
    OP_GETSTATUS = 3'd2,
    OP_CLRSTATUS = 3'd3,
    OP_GETSTATE  = 3'd4,
    OP_ABORT     = 3'd5,
    OP_COMPLETE  = 3'd6,
    OP_OTHER     = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_ERASE   = 3'd1,
    ACT_PROGRAM = 3'd2,
    ACT_DETACH  = 3'd3,
    ACT_READ    = 3'd4
  } action_t;

  typedef struct packed {
    logic        accepted;
    logic        stall_res;
    logic        status_code;
    logic [23:0] poll_timeout;
    logic [3:0]  state_out;
    logic [2:0]  reply_len;
    logic        complete_pending;
    logic [2:0]  action;
    logic [31:0] action_addr;
    logic [10:0] action_len;
  } res_t;

endpackage

[hw/rtl/udfu_if.sv]
`timescale 1ns / 1ps
// Request and result channel interfaces of the DFU request engine.
// Valid/ready handshake; no package dependency.
interface udfu_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [7:0]  req_type;
  logic [15:0] block_num;
  logic [10:0] length;
  logic [39:0] payload_head;

  modport source (output valid, op, req_type, block_num, length, payload_head,
                  input ready);
  modport sink (input valid, op, req_type, block_num, length, payload_head,
                output ready);
endinterface

interface udfu_res_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic        stall_res;
  logic        status_code;
  logic [23:0] poll_timeout;
  logic [3:0]  state_out;
  logic [2:0]  reply_len;
  logic        complete_pending;
  logic [2:0]  action;
  logic [31:0] action_addr;
  logic [10:0] action_len;

  modport source (output valid, accepted, stall_res, status_code, poll_timeout,
                  state_out, reply_len, complete_pending, action, action_addr,
                  action_len, input ready);
  modport sink (input valid, accepted, stall_res, status_code, poll_timeout,
                state_out, reply_len, complete_pending, action, action_addr,
                action_len, output ready);
endinterface

[hw/rtl/usb_dfu_request_state_machine.sv]
`timescale 1ns / 1ps
// DFU class request engine: one request in, one result out.
// Result is registered: valid in the cycle after the request is accepted; one request
// per cycle, held back only while the result register is full and not taken.
// Synchronous active-high reset: state dfuIDLE, block/command record zero,
// configuration registers to their defaults, result register empty.
// Depends on udfu_pkg and udfu_if.
module usb_dfu_request_state_machine
  import udfu_pkg::*;
#(
  parameter int unsigned TRANSFER_SIZE = TRANSFER_SIZE_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  udfu_req_if.sink             req,
  udfu_res_if.source           res,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  dfu_state_t  state, state_next;
  logic        err, err_next;
  logic [15:0] last_block, last_block_next;
  logic [10:0] last_len, last_len_next;
  logic [7:0]  cmd_byte, cmd_byte_next;
  logic [31:0] cmd_addr, cmd_addr_next;
  logic [31:0] base_addr, base_addr_next;

  logic [31:0] app_start, flash_end;
  logic [23:0] poll_wait_ms;

  logic        res_valid;
  res_t        res_q, res_next;

  logic        take;
  logic [10:0] len_c;
  logic        class_ok;
  logic [7:0]  head_cmd;
  logic [31:0] head_addr;
  logic [31:0] prog_addr, read_addr;

  assign req.ready = !res_valid || res.ready;
  assign take      = req.valid && req.ready;

  assign len_c = (32'(req.length) > 32'(TRANSFER_SIZE)) ? 11'(TRANSFER_SIZE) : req.length;
  assign class_ok  = (req.req_type[6:0] == REQ_TYPE_CLASS);
  assign head_cmd  = req.payload_head[7:0];
  assign head_addr = req.payload_head[39:8];

  assign prog_addr = base_addr
                   + 32'((32'(last_block) - 32'd2) * 32'(TRANSFER_SIZE));
  assign read_addr = base_addr
                   + 32'((32'(req.block_num) - 32'd2) * 32'(TRANSFER_SIZE));

  always_comb begin
    state_next      = state;
    err_next        = err;
    last_block_next = last_block;
    last_len_next   = last_len;
    cmd_byte_next   = cmd_byte;
    cmd_addr_next   = cmd_addr;
    base_addr_next  = base_addr;
    res_next        = '0;

    unique case (op_t'(req.op))
      OP_COMPLETE: begin
        res_next.accepted = 1'b1;
        if (state == ST_DNBUSY) begin
          if (last_block == 16'd0) begin
            if (cmd_byte == CMD_ERASE_SECTOR) begin
              res_next.action      = ACT_ERASE;
              res_next.action_addr = cmd_addr;
            end
          end else begin
            res_next.action      = ACT_PROGRAM;
            res_next.action_addr = prog_addr;
            res_next.action_len  = last_len;
          end
          state_next = ST_DNIDLE;
        end else if (state == ST_MANIFEST) begin
          res_next.action = ACT_DETACH;
        end
      end
      OP_DNLOAD: begin
        if (class_ok) begin
          res_next.accepted = 1'b1;
          if (len_c == 11'd0) begin
            state_next = ST_MANSYNC;
          end else begin
            last_block_next = req.block_num;
            last_len_next   = len_c;
            cmd_byte_next   = head_cmd;
            cmd_addr_next   = head_addr;
            if (req.block_num == 16'd0 && head_cmd == CMD_SET_ADDRESS &&
                (head_addr < app_start || head_addr >= flash_end)) begin
              err_next   = 1'b1;
              state_next = ST_ERROR;
            end else begin
              if (req.block_num == 16'd0 && head_cmd == CMD_SET_ADDRESS) begin
                base_addr_next = head_addr;
              end
              state_next = ST_DNSYNC;
            end
          end
        end
      end
      OP_UPLOAD: begin
        if (class_ok) begin
          if (state == ST_IDLE || state == ST_DNIDLE || state == ST_UPIDLE) begin
            res_next.accepted = 1'b1;
            last_block_next   = req.block_num;
            state_next        = ST_UPIDLE;
            if (req.block_num > 16'd1) begin
              res_next.action      = ACT_READ;
              res_next.action_addr = read_addr;
              res_next.action_len  = len_c;
            end
          end else begin
            res_next.stall_res = 1'b1;
          end
        end
      end
      OP_GETSTATUS: begin
        if (class_ok) begin
          res_next.accepted = 1'b1;
          if (state == ST_DNSYNC) begin
            state_next            = ST_DNBUSY;
            res_next.poll_timeout = poll_wait_ms;
          end else if (state == ST_MANSYNC) begin
            state_next = ST_MANIFEST;
          end else if (state == ST_ERROR) begin
            res_next.status_code = err;
          end
          res_next.reply_len        = REPLY_LEN_STATUS;
          res_next.complete_pending = 1'b1;
        end
      end
      OP_CLRSTATUS: begin
        if (class_ok) begin
          res_next.accepted = 1'b1;
          if (state == ST_ERROR) begin
            state_next = ST_IDLE;
          end
        end
      end
      OP_GETSTATE: begin
        if (class_ok) begin
          res_next.accepted  = 1'b1;
          res_next.reply_len = REPLY_LEN_STATE;
        end
      end
      OP_ABORT: begin
        if (class_ok) begin
          res_next.accepted = 1'b1;
          state_next        = ST_IDLE;
        end
      end
      OP_OTHER: begin
      end
      default: begin
      end
    endcase

    res_next.state_out = state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      err        <= 1'b0;
      last_block <= '0;
      last_len   <= '0;
      cmd_byte   <= '0;
      cmd_addr   <= '0;
      base_addr  <= '0;
    end else if (take) begin
      state      <= state_next;
      err        <= err_next;
      last_block <= last_block_next;
      last_len   <= last_len_next;
      cmd_byte   <= cmd_byte_next;
      cmd_addr   <= cmd_addr_next;
      base_addr  <= base_addr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      app_start    <= APP_START_RST;
      flash_end    <= FLASH_END_RST;
      poll_wait_ms <= POLL_WAIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_APP_START: app_start    <= cfg_data;
        CFG_FLASH_END: flash_end    <= cfg_data;
        CFG_POLL_WAIT: poll_wait_ms <= cfg_data[23:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_q <= res_next;
    end
  end

  assign res.valid            = res_valid;
  assign res.accepted         = res_q.accepted;
  assign res.stall_res        = res_q.stall_res;
  assign res.status_code      = res_q.status_code;
  assign res.poll_timeout     = res_q.poll_timeout;
  assign res.state_out        = res_q.state_out;
  assign res.reply_len        = res_q.reply_len;
  assign res.complete_pending = res_q.complete_pending;
  assign res.action           = res_q.action;
  assign res.action_addr      = res_q.action_addr;
  assign res.action_len       = res_q.action_len;

endmodule
